// ----- sv/assert_macros.svh -----
// Assertion macros shared by the clipper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/plc_pkg.sv -----
// Package for the parametric line clipper: widths, types and register indexes.
package plc_pkg;

    localparam int CB    = 13;             // coordinate width
    localparam int FB    = 16;             // fractional bits of t
    localparam int DW    = CB + 1;         // width of differences p and q
    localparam int MAGW  = DW;             // magnitude of a difference
    localparam int DIVW  = MAGW + FB + 2;  // divider dividend and quotient width
    localparam int VW    = MAGW + 1;       // divider divisor width
    localparam int RW    = VW + 1;         // divider partial remainder width
    localparam int TW    = DIVW + 1;       // signed t width
    localparam int UTW   = FB + 1;         // t in [0, ONE]
    localparam int PW    = UTW + 1 + DW;   // product t * d width
    localparam int SW    = PW + 1;         // sum before rounding shift
    localparam int NEDGE = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int IN_TDW  = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_TDW = ((4 * CB + 7) / 8) * 8;

    localparam logic [UTW-1:0] ONE_T  = UTW'(1) << FB;
    localparam logic [SW-1:0]  HALF_T = SW'(1) << (FB - 1);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_BOTTOM = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_TOP    = 2'd3
    } t_cfg_idx;

    // segment after the front end: start point, deltas, q per edge and edge class
    typedef struct packed {
        logic [CB-1:0]            x1;
        logic [CB-1:0]            y1;
        logic [DW-1:0]            dx;
        logic [DW-1:0]            dy;
        logic [NEDGE-1:0][DW-1:0] q;
        logic [NEDGE-1:0]         pzero;
        logic [NEDGE-1:0]         pneg;
        logic [NEDGE-1:0]         qneg;
    } t_item;

    // data carried beside the dividers
    typedef struct packed {
        logic [CB-1:0]    x1;
        logic [CB-1:0]    y1;
        logic [DW-1:0]    dx;
        logic [DW-1:0]    dy;
        logic [NEDGE-1:0] pzero;
        logic [NEDGE-1:0] pneg;
        logic [NEDGE-1:0] qneg;
    } t_side;

    // fifo status toward the front and back ends
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

// ----- sv/plc_front.sv -----
// Front end: window registers, segment intake and per-edge classification.
module plc_front import plc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [CB-1:0]     i_cfg_wdata,
    input  logic              i_valid,
    input  logic [IN_TDW-1:0] i_data,
    input  t_fifo_stat        i_stat,
    output logic              o_ready,
    output logic              o_wr_en,
    output t_item             o_item
);

    logic [CB-1:0] r_left, r_bottom, r_right, r_top;
    logic [CB-1:0] x1, y1, x2, y2;
    logic [DW-1:0] dx, dy;

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_bottom <= '0;
            r_right  <= CB'(4095);
            r_top    <= CB'(4095);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_LEFT:   r_left   <= i_cfg_wdata;
                CFG_BOTTOM: r_bottom <= i_cfg_wdata;
                CFG_RIGHT:  r_right  <= i_cfg_wdata;
                CFG_TOP:    r_top    <= i_cfg_wdata;
                default:    r_left   <= r_left;
            endcase
        end
    end

    // unpack and sign-extend
    assign x1 = i_data[CB-1:0];
    assign y1 = i_data[2*CB-1:CB];
    assign x2 = i_data[3*CB-1:2*CB];
    assign y2 = i_data[4*CB-1:3*CB];

    function automatic logic [DW-1:0] sx(input logic [CB-1:0] v);
        return {v[CB-1], v};
    endfunction

    assign dx = sx(x2) - sx(x1);
    assign dy = sx(y2) - sx(y1);

    // p per edge is -dx, dx, -dy, dy; only its class travels on
    always_comb begin
        o_item.x1   = x1;
        o_item.y1   = y1;
        o_item.dx   = dx;
        o_item.dy   = dy;
        o_item.q[0] = sx(x1) - sx(r_left);
        o_item.q[1] = sx(r_right) - sx(x1);
        o_item.q[2] = sx(y1) - sx(r_bottom);
        o_item.q[3] = sx(r_top) - sx(y1);
        o_item.pzero = {dy == '0, dy == '0, dx == '0, dx == '0};
        o_item.pneg  = {dy[DW-1], !dy[DW-1] && dy != '0,
                        dx[DW-1], !dx[DW-1] && dx != '0};
        for (int e = 0; e < NEDGE; e++) begin
            o_item.qneg[e] = o_item.q[e][DW-1];
        end
    end

    assign o_ready = !i_stat.full;
    assign o_wr_en = i_valid && !i_stat.full;

endmodule

// ----- sv/plc_fifo.sv -----
// Short queue between front and back ends.
`include "assert_macros.svh"
module plc_fifo import plc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_en,
    input  t_item      i_item,
    input  logic       i_rd_en,
    output t_item      o_item,
    output t_fifo_stat o_stat
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            if (i_rd_en) r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            r_count <= r_count + (FIFO_AW+1)'(i_wr_en) - (FIFO_AW+1)'(i_rd_en);
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_wr_en && o_stat.full), "fifo overflow")
    `ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_rd_en && o_stat.empty), "fifo underflow")
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= (FIFO_AW+1)'(FIFO_DEPTH),
        "fifo count out of range")

endmodule

// ----- sv/plc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module plc_div import plc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [DIVW-1:0] i_dividend,
    input  logic [VW-1:0]   i_divisor,
    output logic [DIVW-1:0] o_quot
);

    typedef struct packed {
        logic [RW-1:0]   rem;
        logic [DIVW-1:0] dq;   // dividend bits shift out, quotient bits shift in
        logic [VW-1:0]   dv;
    } t_dstage;

    t_dstage r_st [DIVW];
    t_dstage init;

    function automatic t_dstage f_step(input t_dstage s);
        t_dstage       o;
        logic [RW-1:0] rsh;
        logic          ge;
        rsh  = {s.rem[RW-2:0], s.dq[DIVW-1]};
        ge   = (rsh >= {1'b0, s.dv});
        o.rem = ge ? rsh - {1'b0, s.dv} : rsh;
        o.dq  = {s.dq[DIVW-2:0], ge};
        o.dv  = s.dv;
        return o;
    endfunction

    assign init = '{rem: '0, dq: i_dividend, dv: i_divisor};

    // stage chain
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= f_step(init);
            for (int k = 1; k < DIVW; k++) begin
                r_st[k] <= f_step(r_st[k-1]);
            end
        end
    end

    assign o_quot = r_st[DIVW-1].dq;

endmodule

// ----- sv/plc_back.sv -----
// Back end: edge ratios, bound narrowing, clipped point interpolation, output register.
`include "assert_macros.svh"
module plc_back import plc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_item              i_item,
    input  t_fifo_stat         i_stat,
    output logic               o_rd_en,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_visible,
    output logic [OUT_TDW-1:0] o_data
);

    logic adv;
    logic [DIVW-1:0] quot [NEDGE];
    logic [DIVW-1:0] dividend [NEDGE];
    logic [VW-1:0]   divisor [NEDGE];

    t_side         r_side [DIVW];
    logic [DIVW-1:0] r_dvld;

    logic            r_b_vld, r_b_ok;
    logic [UTW-1:0]  r_t1, r_t2;
    t_side           r_b_side;

    logic            r_m_vld, r_m_ok;
    logic [CB-1:0]   r_m_x1, r_m_y1;
    logic [PW-1:0]   r_prod [NEDGE];

    logic            r_out_vld, r_vis;
    logic [CB-1:0]   r_c [NEDGE];

    // whole pipe moves when the output slot is free or being taken
    assign adv     = !r_out_vld || i_ready;
    assign o_rd_en = adv && !i_stat.empty;

    function automatic logic [MAGW-1:0] f_abs(input logic [DW-1:0] v);
        return v[DW-1] ? MAGW'(-v) : MAGW'(v);
    endfunction

    // divider operands: round(|q| * ONE / |p|) = floor((2|q|ONE + |p|) / 2|p|)
    always_comb begin
        for (int e = 0; e < NEDGE; e++) begin
            divisor[e]  = {(e < 2) ? f_abs(i_item.dx) : f_abs(i_item.dy), 1'b0};
            dividend[e] = {1'b0, f_abs(i_item.q[e]), {(FB+1){1'b0}}}
                          + DIVW'(divisor[e][VW-1:1]);
        end
    end

    for (genvar g = 0; g < NEDGE; g++) begin : g_div
        plc_div u_div (
            .i_clk      (i_clk),
            .i_en       (adv),
            .i_dividend (dividend[g]),
            .i_divisor  (divisor[g]),
            .o_quot     (quot[g])
        );
    end

    // side data and valids beside the dividers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= '{x1: i_item.x1, y1: i_item.y1, dx: i_item.dx, dy: i_item.dy,
                           pzero: i_item.pzero, pneg: i_item.pneg, qneg: i_item.qneg};
            for (int k = 1; k < DIVW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
        end else if (adv) begin
            r_dvld <= {r_dvld[DIVW-2:0], !i_stat.empty};
        end
    end

    // bound narrowing over the edges left, right, bottom, top in order
    logic              ok;
    logic [TW-1:0]     t1, t2, t;
    t_side             sd;
    always_comb begin
        sd = r_side[DIVW-1];
        ok = 1'b1;
        t1 = '0;
        t2 = TW'(ONE_T);
        t  = '0;
        for (int e = 0; e < NEDGE; e++) begin
            t = (sd.qneg[e] ^ sd.pneg[e]) ? TW'(-{1'b0, quot[e]}) : {1'b0, quot[e]};
            if (ok) begin
                if (sd.pzero[e]) begin
                    if (sd.qneg[e]) ok = 1'b0;
                end else if (sd.pneg[e]) begin
                    if ($signed(t) > $signed(t2)) ok = 1'b0;
                    else if ($signed(t) > $signed(t1)) t1 = t;
                end else begin
                    if ($signed(t) < $signed(t1)) ok = 1'b0;
                    else if ($signed(t) < $signed(t2)) t2 = t;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_ok   <= ok;
            r_t1     <= t1[UTW-1:0];
            r_t2     <= t2[UTW-1:0];
            r_b_side <= sd;
        end
    end

    // products t * d
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_ok    <= r_b_ok;
            r_m_x1    <= r_b_side.x1;
            r_m_y1    <= r_b_side.y1;
            r_prod[0] <= PW'($signed({1'b0, r_t1}) * $signed(r_b_side.dx));
            r_prod[1] <= PW'($signed({1'b0, r_t1}) * $signed(r_b_side.dy));
            r_prod[2] <= PW'($signed({1'b0, r_t2}) * $signed(r_b_side.dx));
            r_prod[3] <= PW'($signed({1'b0, r_t2}) * $signed(r_b_side.dy));
        end
    end

    // round to nearest, ties up: floor((base*ONE + t*d + ONE/2) / ONE)
    logic [SW-1:0] sum [NEDGE];
    logic [CB-1:0] base [NEDGE];
    always_comb begin
        base[0] = r_m_x1;
        base[1] = r_m_y1;
        base[2] = r_m_x1;
        base[3] = r_m_y1;
        for (int e = 0; e < NEDGE; e++) begin
            sum[e] = {{(SW-CB-FB){base[e][CB-1]}}, base[e], {FB{1'b0}}}
                     + {r_prod[e][PW-1], r_prod[e]} + HALF_T;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_vis <= r_m_ok;
            for (int e = 0; e < NEDGE; e++) begin
                r_c[e] <= r_m_ok ? sum[e][FB+CB-1:FB] : '0;
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_m_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld   <= r_dvld[DIVW-1];
            r_m_vld   <= r_b_vld;
            r_out_vld <= r_m_vld;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_visible = r_vis;
    assign o_data    = {{(OUT_TDW-4*CB){1'b0}}, r_c[3], r_c[2], r_c[1], r_c[0]};

    `ASSERT_IMPLY(a_hidden_zero, i_clk, i_rst_n, r_out_vld && !r_vis, o_data == '0,
        "rejected segment with nonzero coordinates")
    `ASSERT_IMPLY(a_bounds_order, i_clk, i_rst_n, r_b_vld && r_b_ok,
        (r_t1 <= r_t2) && (r_t2 <= ONE_T), "clip bounds out of order")
    `ASSERT_IMPLY(a_stall_hold, i_clk, i_rst_n, r_out_vld && !i_ready,
        !o_rd_en, "queue popped while output stalled")

endmodule

// ----- sv/parametric_line_clipper_top.sv -----
// Top level of the parametric line clipper.
// Clips line segments against a rectangular window (Liang-Barsky).
// Input stream s_axis: one segment per transaction, tdata holds start_x,
// start_y, end_x, end_y (13-bit signed each). Output stream m_axis: one result
// per segment, tuser is the visible flag, tdata the clipped start_x, start_y,
// end_x, end_y (13-bit signed, zero when not visible).
// Configuration: i_cfg_we with i_cfg_addr 0..3 writes window left, bottom,
// right, top; write only while no segment is in flight.
// Throughput: one segment per cycle while the receiver takes results. The
// 32-stage divider, one quotient bit per stage, computes each edge ratio and is
// followed by bound, multiply and output stages; the queue sits in front of it.
// Reset (synchronous, active low) empties the queue and pipeline and sets the
// window to left 0, bottom 0, right 4095, top 4095.
// When the receiver stalls, the whole back pipeline holds; the 4-entry queue
// keeps taking segments until full, then s_axis tready drops.
module parametric_line_clipper_top import plc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [CB-1:0]      i_cfg_wdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [IN_TDW-1:0]  i_s_axis_tdata,   // start_x, start_y, end_x, end_y, pad
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [OUT_TDW-1:0] o_m_axis_tdata,   // clip_start_x, clip_start_y,
                                                 // clip_end_x, clip_end_y, pad
    output logic               o_m_axis_tuser    // visible
);

    t_item      front_item, fifo_item;
    t_fifo_stat fifo_stat;
    logic       wr_en, rd_en;

    plc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_data      (i_s_axis_tdata),
        .i_stat      (fifo_stat),
        .o_ready     (o_s_axis_tready),
        .o_wr_en     (wr_en),
        .o_item      (front_item)
    );

    plc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (wr_en),
        .i_item  (front_item),
        .i_rd_en (rd_en),
        .o_item  (fifo_item),
        .o_stat  (fifo_stat)
    );

    plc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (fifo_item),
        .i_stat    (fifo_stat),
        .o_rd_en   (rd_en),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_visible (o_m_axis_tuser),
        .o_data    (o_m_axis_tdata)
    );

endmodule

// ----- bench/parametric_line_clipper_top_tb.sv -----
// Self-checking testbench for the parametric line clipper: random and directed segments.
`timescale 1ns / 1ps

module parametric_line_clipper_top_tb;
    import plc_pkg::*;

    localparam int FRAC     = FB;
    localparam int LATENCY  = 40;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic          vis;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
    } t_clip;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_addr;
    logic [CB-1:0]      i_cfg_wdata;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [IN_TDW-1:0]  i_s_axis_tdata;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [OUT_TDW-1:0] o_m_axis_tdata;
    logic               o_m_axis_tuser;

    parametric_line_clipper_top u_top (.*);

    // window copy used by the predictor
    longint win_l, win_b, win_r, win_t;

    logic [IN_TDW-1:0] seg_q[$];
    t_clip             clip_q[$];
    int                err_cnt;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                idle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint sx13(logic [CB-1:0] v);
        return longint'(signed'(v));
    endfunction

    // edge ratio q*ONE/p, rounded to nearest with ties away from zero
    function automatic longint edge_ratio(longint q, longint p);
        longint nq, np, mag;
        nq  = (q < 0) ? -q : q;
        np  = (p < 0) ? -p : p;
        mag = (2 * (nq <<< FRAC) + np) / (2 * np);
        return ((q < 0) != (p < 0)) ? -mag : mag;
    endfunction

    // coordinate at parameter t, rounded with ties toward plus infinity
    function automatic logic [CB-1:0] coord_at(longint base, longint t, longint d);
        longint v;
        v = base * (longint'(1) <<< FRAC) + t * d + (longint'(1) <<< (FRAC - 1));
        return CB'(v >>> FRAC);
    endfunction

    function automatic t_clip clip_segment(logic [IN_TDW-1:0] seg);
        longint x1, y1, x2, y2, dx, dy, t, t1, t2;
        longint p[4];
        longint q[4];
        bit     ok;
        t_clip  r;
        x1 = sx13(seg[0*CB +: CB]);
        y1 = sx13(seg[1*CB +: CB]);
        x2 = sx13(seg[2*CB +: CB]);
        y2 = sx13(seg[3*CB +: CB]);
        dx = x2 - x1;
        dy = y2 - y1;
        t1 = 0;
        t2 = longint'(1) <<< FRAC;
        ok = 1'b1;
        p[0] = -dx; q[0] = x1 - win_l;
        p[1] = dx;  q[1] = win_r - x1;
        p[2] = -dy; q[2] = y1 - win_b;
        p[3] = dy;  q[3] = win_t - y1;
        for (int i = 0; i < 4; i++) begin
            if (ok) begin
                if (p[i] == 0) begin
                    if (q[i] < 0) ok = 1'b0;
                end else begin
                    t = edge_ratio(q[i], p[i]);
                    if (p[i] < 0) begin
                        if (t > t2) ok = 1'b0;
                        else if (t > t1) t1 = t;
                    end else begin
                        if (t < t1) ok = 1'b0;
                        else if (t < t2) t2 = t;
                    end
                end
            end
        end
        r = '0;
        if (ok) begin
            r.vis = 1'b1;
            r.sx  = coord_at(x1, t1, dx);
            r.sy  = coord_at(y1, t1, dy);
            r.ex  = coord_at(x1, t2, dx);
            r.ey  = coord_at(y1, t2, dy);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // driver: stream segments from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                clip_q.push_back(clip_segment(i_s_axis_tdata));
            if (seg_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= seg_q.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check results and apply receiver backpressure
    always @(posedge i_clk) begin
        t_clip got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            idle_cnt        <= 0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.vis = o_m_axis_tuser;
                got.sx  = o_m_axis_tdata[0*CB +: CB];
                got.sy  = o_m_axis_tdata[1*CB +: CB];
                got.ex  = o_m_axis_tdata[2*CB +: CB];
                got.ey  = o_m_axis_tdata[3*CB +: CB];
                if (clip_q.size() == 0) begin
                    report_mismatch("unexpected result, visible", got.vis, -1);
                end else begin
                    want = clip_q.pop_front();
                    if (got.vis !== want.vis) report_mismatch("visible", got.vis, want.vis);
                    if (got.sx !== want.sx) report_mismatch("clip_start_x", sx13(got.sx), sx13(want.sx));
                    if (got.sy !== want.sy) report_mismatch("clip_start_y", sx13(got.sy), sx13(want.sy));
                    if (got.ex !== want.ex) report_mismatch("clip_end_x", sx13(got.ex), sx13(want.ex));
                    if (got.ey !== want.ey) report_mismatch("clip_end_y", sx13(got.ey), sx13(want.ey));
                end
            end
        end
    end

    // watchdog: no transaction for too long ends the run
    always @(posedge i_clk) begin
        if (idle_cnt >= WD_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", clip_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [IN_TDW-1:0] pack_seg(longint x1, longint y1, longint x2, longint y2);
        logic [IN_TDW-1:0] s;
        s = '0;
        s[0*CB +: CB] = CB'(x1);
        s[1*CB +: CB] = CB'(y1);
        s[2*CB +: CB] = CB'(x2);
        s[3*CB +: CB] = CB'(y2);
        return s;
    endfunction

    function automatic longint rand_coord();
        case ($urandom_range(3))
            0: return longint'($urandom_range(8191)) - 4096;
            1: return (win_l + win_r) / 2 + longint'($urandom_range(400)) - 200;
            2: return ($urandom_range(1)) ? 4095 : -4096;
            default: return longint'($urandom_range(2000)) - 1000;
        endcase
    endfunction

    function automatic longint clamp13(longint v);
        return (v > 4095) ? 4095 : ((v < -4096) ? -4096 : v);
    endfunction

    task automatic cfg_write(t_cfg_idx idx, longint val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= CB'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_LEFT:   win_l = val;
            CFG_BOTTOM: win_b = val;
            CFG_RIGHT:  win_r = val;
            default:    win_t = val;
        endcase
    endtask

    task automatic set_window(longint l, longint b, longint r, longint t);
        cfg_write(CFG_LEFT, l);
        cfg_write(CFG_BOTTOM, b);
        cfg_write(CFG_RIGHT, r);
        cfg_write(CFG_TOP, t);
    endtask

    // wait until all queued segments have been checked, then let the pipe drain
    task automatic drain();
        wait (seg_q.size() == 0 && !i_s_axis_tvalid && clip_q.size() == 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        longint x1, y1;
        for (int i = 0; i < n; i++) begin
            x1 = rand_coord();
            y1 = rand_coord();
            case ($urandom_range(5))
                0: seg_q.push_back(pack_seg(x1, y1, x1, y1));
                1: seg_q.push_back(pack_seg(x1, y1, x1, rand_coord()));
                2: seg_q.push_back(pack_seg(x1, y1, rand_coord(), y1));
                3: seg_q.push_back(pack_seg(x1, y1,
                       clamp13(x1 + longint'($urandom_range(6)) - 3),
                       clamp13(y1 + longint'($urandom_range(6)) - 3)));
                default: seg_q.push_back(pack_seg(x1, y1, rand_coord(), rand_coord()));
            endcase
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        err_cnt         = 0;
        idle_cnt        = 0;
        send_idle_pct   = 34;
        recv_idle_pct   = 73;
        win_l = 0; win_b = 0; win_r = 4095; win_t = 4095;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset window, then a small window
        seg_q.push_back(pack_seg(-4096, -4096, 4095, 4095));
        seg_q.push_back(pack_seg(4095, 4095, -4096, -4096));
        seg_q.push_back(pack_seg(100, 100, 100, 100));       // point inside
        seg_q.push_back(pack_seg(-5, 100, -5, 100));         // point outside
        seg_q.push_back(pack_seg(-100, 50, 5000 - 8192, 50)); // fully left
        seg_q.push_back(pack_seg(-4096, 0, 4095, 0));        // on bottom edge
        drain();
        set_window(-100, -50, 200, 150);
        seg_q.push_back(pack_seg(-4096, 0, 4095, 0));        // horizontal through
        seg_q.push_back(pack_seg(0, -4096, 0, 4095));        // vertical through
        seg_q.push_back(pack_seg(-300, -300, 300, 300));     // diagonal through
        seg_q.push_back(pack_seg(300, 300, -300, -300));
        seg_q.push_back(pack_seg(-300, 200, 300, 200));      // above window
        seg_q.push_back(pack_seg(-300, 400, 400, -400));     // crosses top and bottom
        seg_q.push_back(pack_seg(-100, -50, 200, 150));      // corner to corner
        seg_q.push_back(pack_seg(0, 0, 1, 1));               // short inside
        seg_q.push_back(pack_seg(-101, 0, -101, 0));         // point just left
        drain();
        // inverted window
        set_window(100, 100, -100, -100);
        seg_q.push_back(pack_seg(-4096, -4096, 4095, 4095));
        seg_q.push_back(pack_seg(0, 0, 0, 0));
        seg_q.push_back(pack_seg(-200, 0, 200, 1));
        drain();

        // random phases over several windows, sender/receiver idling varied
        set_window(-4096, -4096, 4095, 4095);
        add_random(300);
        drain();
        set_window(-200, -100, 300, 250);
        add_random(300);
        drain();
        send_idle_pct = 73;
        recv_idle_pct = 34;
        set_window(4095, 4095, 4095, 4095);
        add_random(100);
        drain();
        set_window(-1000, 500, 1000, -500);
        add_random(100);
        drain();
        set_window(-2000, -1500, 2500, 1800);
        add_random(300);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_window(-4096, -4096, -4096, -4096);
        add_random(100);
        drain();
        set_window(-50, -60, 70, 80);
        add_random(400);
        drain();

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
